>>> rtl/stt_pkg.sv
package stt_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_QUERY  = 2'd2
	} stt_cmd_t;

	localparam int unsigned TIME_W  = 31;
	localparam int unsigned REF_W   = 16;
	localparam int unsigned FIDX_W  = 6;
	localparam int unsigned FCNT_W  = 7;

	typedef struct packed {
		logic [1:0]        command;
		logic [TIME_W-1:0] time_ms;
		logic [REF_W-1:0]  line_ref;
	} stt_in_t;

	typedef struct packed {
		logic              accepted;
		logic              table_empty;
		logic [FIDX_W-1:0] found_index;
		logic [REF_W-1:0]  found_ref;
		logic [FCNT_W-1:0] entry_count;
	} stt_out_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic              insert;
		logic              query;
		logic [TIME_W-1:0] time_ms;
		logic [REF_W-1:0]  line_ref;
	} stt_bus_t;

endpackage

>>> rtl/stt_cell.sv
module stt_cell #(
	parameter int unsigned CNT_W = 7,
	parameter int unsigned IDX   = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stt_pkg::stt_bus_t            bus,
	input  logic [CNT_W-1:0]             count,
	input  logic                         prev_le,
	input  logic                         prev_gt,
	input  logic [stt_pkg::TIME_W-1:0]   prev_time,
	input  logic [stt_pkg::REF_W-1:0]    prev_ref,
	input  logic                         next_le,
	output logic                         le,
	output logic                         gt,
	output logic [stt_pkg::TIME_W-1:0]   time_q,
	output logic [stt_pkg::REF_W-1:0]    ref_q,
	output logic                         hit_q
);
	import stt_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
	localparam logic             FIRST = (IDX == 0);

	logic occ;
	logic is_pos;

	assign occ    = IDX_C < count;
	assign le     = occ && (time_q <= bus.time_ms);
	assign gt     = occ && (time_q > bus.time_ms);
	// first cell that is free or later than the new time
	assign is_pos = prev_le && (gt || !occ);

	always_ff @(posedge clk) begin
		if (bus.insert) begin
			if (prev_gt) begin
				time_q <= prev_time;
				ref_q  <= prev_ref;
			end else if (is_pos) begin
				time_q <= bus.time_ms;
				ref_q  <= bus.line_ref;
			end
		end
	end

	// last cell at or below the play time; cell zero also wins when none is
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (bus.query) begin
			hit_q <= (FIRST || le) && !next_le;
		end
	end

endmodule

>>> rtl/stt_select.sv
module stt_select #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IDX_W = 6
) (
	input  logic [DEPTH-1:0]                        hit,
	input  logic [DEPTH-1:0][stt_pkg::REF_W-1:0]    refs,
	output logic [IDX_W-1:0]                        index,
	output logic [stt_pkg::REF_W-1:0]               line_ref
);
	import stt_pkg::*;

	logic [IDX_W-1:0][DEPTH-1:0] icol;
	logic [REF_W-1:0][DEPTH-1:0] rcol;

	// hit is one-hot, so OR trees encode the index and pick the reference
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		for (genvar b = 0; b < IDX_W; b++) begin : g_ib
			assign icol[b][i] = hit[i] & ((i >> b) % 2 == 1);
		end
		for (genvar b = 0; b < REF_W; b++) begin : g_rb
			assign rcol[b][i] = hit[i] & refs[i][b];
		end
	end

	for (genvar b = 0; b < IDX_W; b++) begin : g_ired
		assign index[b] = |icol[b];
	end
	for (genvar b = 0; b < REF_W; b++) begin : g_rred
		assign line_ref[b] = |rcol[b];
	end

endmodule

>>> rtl/sorted_timestamp_table_unit.sv
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req (stt_in_t: command, time_ms, line_ref)
// result  | rsp_valid | rsp_stall | rsp (stt_out_t)
//
// One item per cycle sustained while the result is not stalled; on the transfer
// edge the cell row compares and shifts and registers its hit flags, then the
// one-hot select tree feeds the result register once the compare stage advances.
// Reset clears the entry count and the valid flags; cell contents need no clearing pass.
// A stalled result holds an occupied compare stage, which then stalls requests.
module sorted_timestamp_table_unit #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  stt_pkg::stt_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output stt_pkg::stt_out_t rsp
);
	import stt_pkg::*;

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(TABLE_DEPTH);

	typedef struct packed {
		logic             accepted;
		logic             empty;
		logic             query;
		logic [CNT_W-1:0] count;
	} s1_info_t;

	logic             xfer;
	logic             s1_adv;
	logic             full;
	stt_bus_t         bus;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	s1_info_t         info_nxt;
	s1_info_t         info_s1;
	logic             valid_s1;
	stt_out_t         rsp_q;
	logic             rsp_valid_q;

	logic [TABLE_DEPTH-1:0]                le_w;
	logic [TABLE_DEPTH-1:0]                gt_w;
	logic [TABLE_DEPTH-1:0]                hit_w;
	logic [TABLE_DEPTH-1:0][TIME_W-1:0]    time_w;
	logic [TABLE_DEPTH-1:0][REF_W-1:0]     ref_w;
	logic [IDX_W-1:0]                      sel_idx;
	logic [REF_W-1:0]                      sel_ref;
	logic [IDX_W+FIDX_W-1:0]               idx_ext;
	logic [CNT_W+FCNT_W-1:0]               cnt_ext;

	assign s1_adv    = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !s1_adv;
	assign xfer      = req_valid && !req_stall;
	assign full      = count_q == FULL_C;

	assign bus.insert   = xfer && (req.command == CMD_INSERT) && !full;
	assign bus.query    = xfer && (req.command == CMD_QUERY);
	assign bus.time_ms  = req.time_ms;
	assign bus.line_ref = req.line_ref;

	always_comb begin
		count_nxt = count_q;
		info_nxt  = '0;
		case (req.command)
			CMD_CLEAR: begin
				count_nxt         = '0;
				info_nxt.accepted = 1'b1;
			end
			CMD_INSERT: begin
				if (!full) begin
					count_nxt         = count_q + CNT_W'(1);
					info_nxt.accepted = 1'b1;
				end
			end
			CMD_QUERY: begin
				info_nxt.accepted = 1'b1;
				info_nxt.query    = 1'b1;
				info_nxt.empty    = count_q == '0;
			end
			default: begin
				info_nxt.accepted = 1'b0;
			end
		endcase
		info_nxt.count = count_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				count_q <= count_nxt;
			end
			// an empty compare stage takes a transfer even while the result is stalled
			if (!req_stall) begin
				valid_s1 <= xfer;
			end
			if (s1_adv) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			info_s1 <= info_nxt;
		end
		if (s1_adv && valid_s1) begin
			rsp_q <= '{
				accepted:    info_s1.accepted,
				table_empty: info_s1.empty,
				found_index: (info_s1.query && !info_s1.empty) ? idx_ext[FIDX_W-1:0] : '0,
				found_ref:   (info_s1.query && !info_s1.empty) ? sel_ref : '0,
				entry_count: cnt_ext[FCNT_W-1:0]
			};
		end
	end

	assign idx_ext = {{FIDX_W{1'b0}}, sel_idx};
	assign cnt_ext = {{FCNT_W{1'b0}}, info_s1.count};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_row
		if (i == 0) begin : g_head
			stt_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.bus       (bus),
				.count     (count_q),
				.prev_le   (1'b1),
				.prev_gt   (1'b0),
				.prev_time ('0),
				.prev_ref  ('0),
				.next_le   ((TABLE_DEPTH > 1) ? le_w[(TABLE_DEPTH > 1) ? 1 : 0] : 1'b0),
				.le        (le_w[i]),
				.gt        (gt_w[i]),
				.time_q    (time_w[i]),
				.ref_q     (ref_w[i]),
				.hit_q     (hit_w[i])
			);
		end else begin : g_body
			stt_cell #(.CNT_W(CNT_W), .IDX(i)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.bus       (bus),
				.count     (count_q),
				.prev_le   (le_w[i-1]),
				.prev_gt   (gt_w[i-1]),
				.prev_time (time_w[i-1]),
				.prev_ref  (ref_w[i-1]),
				.next_le   ((i == TABLE_DEPTH - 1) ? 1'b0 : le_w[(i + 1) % TABLE_DEPTH]),
				.le        (le_w[i]),
				.gt        (gt_w[i]),
				.time_q    (time_w[i]),
				.ref_q     (ref_w[i]),
				.hit_q     (hit_w[i])
			);
		end
	end

	stt_select #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_select (
		.hit      (hit_w),
		.refs     (ref_w),
		.index    (sel_idx),
		.line_ref (sel_ref)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> rtl/stt_checker.sv
module stt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input stt_pkg::stt_in_t  req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input stt_pkg::stt_out_t rsp
);
	import stt_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.table_empty |->
			rsp.accepted && rsp.found_index == '0 && rsp.found_ref == '0 &&
			rsp.entry_count == '0)
		else $error("empty query carries data");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.accepted |->
			!rsp.table_empty && rsp.found_index == '0 && rsp.found_ref == '0)
		else $error("refused command carries data");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !$isunknown(rsp))
		else $error("result carries unknown bits");

endmodule

bind sorted_timestamp_table_unit stt_checker u_stt_checker (.*);
